[hdl/accumulator_machine_step_core_defines.svh]
// Assertion macros shared by the accumulator machine RTL.
`ifndef ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_STEP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define AMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("accumulator machine assertion failed");
// Next-cycle implication.
`define AMS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("accumulator machine assertion failed");
`else
`define AMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define AMS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/ams_pkg.sv]
// Types, codes and helper functions for the accumulator machine.
`default_nettype none

package ams_pkg;

  localparam int PROGRAM_DEPTH_DEF = 32;
  localparam int DATA_DEPTH_DEF    = 1024;
  localparam int WORD_WIDTH_DEF    = 32;

  localparam logic [4:0] START_PC_RESET = 5'd3;

  // Commands.
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OUTPUT  = 3'd1;
  localparam logic [2:0] ST_HALTED  = 3'd2;
  localparam logic [2:0] ST_BAD_OP  = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  // Instruction opcodes.
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LOAD  = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_STORE = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_IN    = 4'd5;
  localparam logic [3:0] OP_OUT   = 4'd6;
  localparam logic [3:0] OP_END   = 4'd7;
  localparam logic [3:0] OP_JUMP  = 4'd8;
  localparam logic [3:0] OP_SKIPZ = 4'd9;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_ADD  = 2'd1,
    ALU_SUB  = 2'd2
  } alu_op_t;

  // Sequencer phase flags handed to the datapath.
  typedef struct packed {
    logic clearing;
    logic idle;
    logic fetch;
    logic exec;
    logic rd_out;
  } ctl_t;

  // Reduces a 10-bit address modulo a constant depth by shifted
  // compare-and-subtract; a power-of-two depth is a plain mask.
  function automatic logic [9:0] mod_addr(input logic [9:0] x, input int k);
    logic [21:0] r;
    r = 22'(x);
    if ((k & (k - 1)) == 0) begin
      return x & 10'(k - 1);
    end
    for (int j = 8; j >= 0; j--) begin
      if (r >= (22'(k) << j)) begin
        r = r - (22'(k) << j);
      end
    end
    return r[9:0];
  endfunction

endpackage

`default_nettype wire

[hdl/accumulator_machine_step_core.sv]
// Top level of the accumulator machine: memories, registers and datapath.
//
// Channel  Direction  Handshake              Payload
// request  in         start / busy           command, address, opcode, operand, in_value
// result   out        done (one-cycle pulse) status, pc, accumulator, read_data
// config   in         cfg_we                 cfg_wdata (start_pc)
//
// A request is taken at a clock edge with start high and busy low.
// A load, an unused command or a step while halted is answered from the idle state, a read goes
// through the read state (one synchronous data memory read), and an executed step goes through
// program memory fetch, data memory read, then execute in the shared ALU with write back.
// After reset a clearing pass zeroes both memories, one entry per cycle, over
// max(PROGRAM_DEPTH, DATA_DEPTH) addresses (1024 with the defaults); busy stays high meanwhile.
// The receiver cannot stall: done is high for exactly one cycle per request.
`default_nettype none
`include "accumulator_machine_step_core_defines.svh"

module accumulator_machine_step_core #(
  parameter int PROGRAM_DEPTH = ams_pkg::PROGRAM_DEPTH_DEF,
  parameter int DATA_DEPTH    = ams_pkg::DATA_DEPTH_DEF,
  parameter int WORD_WIDTH    = ams_pkg::WORD_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command,
  input  logic [9:0]         address,
  input  logic [3:0]         opcode,
  input  logic [9:0]         operand,
  input  logic signed [31:0] in_value,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  output logic               done,
  output logic [2:0]         status,
  output logic [4:0]         pc,
  output logic signed [31:0] accumulator,
  output logic signed [31:0] read_data
);
  import ams_pkg::*;

  localparam int PW        = $clog2(PROGRAM_DEPTH);
  localparam int DAW       = $clog2(DATA_DEPTH);
  localparam int WW        = WORD_WIDTH;
  localparam int MAX_DEPTH = (PROGRAM_DEPTH > DATA_DEPTH) ? PROGRAM_DEPTH : DATA_DEPTH;
  localparam int CW        = $clog2(MAX_DEPTH);
  localparam logic [PW-1:0] PC_RESET = PW'(mod_addr(10'(START_PC_RESET), PROGRAM_DEPTH));

  // Program words are the opcode above the operand; data words are WW bits wide.
  logic [13:0]   prog_mem [PROGRAM_DEPTH];
  logic [WW-1:0] data_mem [DATA_DEPTH];

  ctl_t          ctl;
  logic [CW-1:0] clr_addr;

  // Architectural state.
  logic [PW-1:0] pc_reg, pc_next;
  logic [WW-1:0] acc_reg, acc_next;
  logic          halted, halted_next;

  // Per-request holding registers.
  logic [13:0]    pword;
  logic [WW-1:0]  rd_data;
  logic [DAW-1:0] daddr_q;
  logic [WW-1:0]  in_q;

  // Memory port controls.
  logic           pm_we, pm_re;
  logic [PW-1:0]  pm_waddr;
  logic [13:0]    pm_wdata;
  logic           dm_we, dm_re;
  logic [DAW-1:0] dm_waddr, dm_raddr;
  logic [WW-1:0]  dm_wdata;

  // Request decode.
  logic accept, step_go, read_go;

  logic [PW-1:0] pc_inc;
  logic [3:0]    op;
  logic [9:0]    arg;

  alu_op_t       alu_op;
  logic [WW-1:0] alu_b, alu_y;
  logic          acc_zero;

  logic          done_next;
  logic [2:0]    status_next;
  logic [31:0]   read_next;

  ams_seq #(
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .DATA_DEPTH    (DATA_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .command  (command),
    .halted   (halted),
    .ctl      (ctl),
    .clr_addr (clr_addr)
  );

  ams_alu #(
    .WORD_WIDTH (WW)
  ) u_alu (
    .op     (alu_op),
    .a      (acc_reg),
    .b      (alu_b),
    .y      (alu_y),
    .a_zero (acc_zero)
  );

  assign busy    = !ctl.idle;
  assign accept  = ctl.idle && start;
  assign step_go = accept && command == CMD_STEP && !halted;
  assign read_go = accept && command == CMD_READ;

  assign op  = pword[13:10];
  assign arg = pword[9:0];

  assign pc_inc = (pc_reg == PW'(PROGRAM_DEPTH - 1)) ? '0 : PW'(pc_reg + 1'b1);

  // Program memory port: the clearing pass and load requests write, a step fetches.
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = PW'(mod_addr(address, PROGRAM_DEPTH));
    pm_wdata = {opcode, operand};
    if (ctl.clearing) begin
      pm_we    = ({1'b0, clr_addr} < (CW + 1)'(PROGRAM_DEPTH));
      pm_waddr = clr_addr[PW-1:0];
      pm_wdata = '0;
    end else if (accept && command == CMD_LOAD) begin
      pm_we = 1'b1;
    end
  end
  assign pm_re = step_go;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      prog_mem[pm_waddr] <= pm_wdata;
    end
    if (pm_re) begin
      pword <= prog_mem[pc_reg];
    end
  end

  // Data memory port: one read address chosen by phase, one write address.
  always_comb begin
    dm_re    = read_go || ctl.fetch;
    dm_raddr = ctl.fetch ? DAW'(mod_addr(arg, DATA_DEPTH))
                         : DAW'(mod_addr(address, DATA_DEPTH));
    dm_we    = 1'b0;
    dm_waddr = daddr_q;
    dm_wdata = acc_reg;
    if (ctl.clearing) begin
      dm_we    = ({1'b0, clr_addr} < (CW + 1)'(DATA_DEPTH));
      dm_waddr = clr_addr[DAW-1:0];
      dm_wdata = '0;
    end else if (ctl.exec && op == OP_STORE) begin
      dm_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dm_we) begin
      data_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      rd_data <= data_mem[dm_raddr];
    end
  end

  // Next-state logic for the accumulator, counter, halt flag and the result.
  always_comb begin
    pc_next     = pc_reg;
    acc_next    = acc_reg;
    halted_next = halted;
    done_next   = 1'b0;
    status_next = ST_OK;
    read_next   = '0;
    alu_op      = ALU_PASS;
    alu_b       = rd_data;

    if (accept && !step_go && !read_go) begin
      // Load, unused command, or a step ignored while halted: answered at once.
      done_next = 1'b1;
      if (command == CMD_STEP) begin
        status_next = ST_IGNORED;
      end
    end

    if (ctl.fetch) begin
      pc_next = pc_inc;
    end

    if (ctl.rd_out) begin
      done_next = 1'b1;
      read_next = 32'($signed(rd_data));
    end

    if (ctl.exec) begin
      done_next = 1'b1;
      case (op)
        OP_NOP: ;
        OP_LOAD: begin
          acc_next = alu_y;
        end
        OP_ADD: begin
          alu_op   = ALU_ADD;
          acc_next = alu_y;
        end
        OP_STORE: ;
        OP_SUB: begin
          alu_op   = ALU_SUB;
          acc_next = alu_y;
        end
        OP_IN: begin
          alu_b    = in_q;
          acc_next = alu_y;
        end
        OP_OUT:  status_next = ST_OUTPUT;
        OP_END: begin
          status_next = ST_HALTED;
          halted_next = 1'b1;
        end
        OP_JUMP: pc_next = PW'(mod_addr(arg, PROGRAM_DEPTH));
        OP_SKIPZ: begin
          if (acc_zero) pc_next = pc_inc;
        end
        default: status_next = ST_BAD_OP;
      endcase
    end

    // A start_pc write reloads the counter; the user must write it only while idle (not enforced here).
    if (cfg_we) begin
      pc_next = PW'(mod_addr(10'(cfg_wdata), PROGRAM_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc_reg  <= PC_RESET;
      acc_reg <= '0;
      halted  <= 1'b0;
      done    <= 1'b0;
    end else begin
      pc_reg  <= pc_next;
      acc_reg <= acc_next;
      halted  <= halted_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    read_data <= read_next;
    if (ctl.fetch) begin
      daddr_q <= dm_raddr;
    end
    if (accept) begin
      in_q <= WW'(in_value);
    end
  end

  // The counter and accumulator only move inside a request or, for the counter, on a start_pc
  // write, so the result pulse shows their final values straight from the registers.
  assign pc          = 5'(pc_reg);
  assign accumulator = 32'($signed(acc_reg));

  `AMS_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `AMS_ASSERT_IMP(a_no_done_clear, clk, rst, ctl.clearing, !done)
  `AMS_ASSERT_NXT(a_halt_sticks, clk, rst, halted, halted)
  `AMS_ASSERT_IMP(a_pc_range, clk, rst, 1'b1, pc_reg <= PW'(PROGRAM_DEPTH - 1))
  `AMS_ASSERT_NXT(a_halted_step, clk, rst, accept && command == CMD_STEP && halted, done && status == ST_IGNORED)

endmodule

`default_nettype wire

[hdl/ams_alu.sv]
// Shared add, subtract and pass unit of the accumulator machine.
`default_nettype none

module ams_alu #(
  parameter int WORD_WIDTH = ams_pkg::WORD_WIDTH_DEF
) (
  input  ams_pkg::alu_op_t        op,
  input  logic [WORD_WIDTH-1:0]   a,
  input  logic [WORD_WIDTH-1:0]   b,
  output logic [WORD_WIDTH-1:0]   y,
  output logic                    a_zero
);
  import ams_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = b;
    endcase
  end

  assign a_zero = (a == '0);

endmodule

`default_nettype wire

[hdl/ams_seq.sv]
// Sequencer of the accumulator machine: clearing pass and command phases.
`default_nettype none

module ams_seq #(
  parameter int PROGRAM_DEPTH = ams_pkg::PROGRAM_DEPTH_DEF,
  parameter int DATA_DEPTH    = ams_pkg::DATA_DEPTH_DEF,
  localparam int MAX_DEPTH    = (PROGRAM_DEPTH > DATA_DEPTH) ? PROGRAM_DEPTH : DATA_DEPTH,
  localparam int CW           = $clog2(MAX_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    command,
  input  logic          halted,
  output ams_pkg::ctl_t ctl,
  output logic [CW-1:0] clr_addr
);
  import ams_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_FETCH = 5'b00100,
    S_EXEC  = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   clr_last;

  assign clr_last = (clr_addr == CW'(MAX_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= CW'(clr_addr + 1'b1);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start && command == CMD_STEP && !halted) begin
          state_next = S_FETCH;
        end else if (start && command == CMD_READ) begin
          state_next = S_READ;
        end
      end
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      S_READ:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign ctl.clearing = (state == S_CLEAR);
  assign ctl.idle     = (state == S_IDLE);
  assign ctl.fetch    = (state == S_FETCH);
  assign ctl.exec     = (state == S_EXEC);
  assign ctl.rd_out   = (state == S_READ);

endmodule

`default_nettype wire

[dv/ams_step_checker.sv]
// Result checker for the accumulator machine: tracks requests, predicts results, compares.
`timescale 1ns / 100ps

module ams_step_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  command,
  input  logic [9:0]  address,
  input  logic [3:0]  opcode,
  input  logic [9:0]  operand,
  input  logic [31:0] in_value,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [4:0]  pc,
  input  logic [31:0] accumulator,
  input  logic [31:0] read_data,
  output int          fail_count,
  output int          outstanding
);
  import ams_pkg::*;

  typedef struct {
    logic [2:0]  status;
    logic [4:0]  pc;
    logic [31:0] acc;
    logic [31:0] rdata;
  } step_outcome_t;

  // Shadow copy of the machine state.
  logic [13:0] prog_words [PROGRAM_DEPTH_DEF];
  logic [31:0] data_words [DATA_DEPTH_DEF];
  logic [4:0]  pc_q;
  logic [31:0] acc_q;
  logic        halted_q;

  step_outcome_t pending_outcomes[$];
  int            mismatches;

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Applies one request to the shadow state and returns the result it must produce.
  // The 5-bit counter wraps at the program depth on its own.
  task automatic predict_step(output step_outcome_t o);
    logic [13:0] word;
    logic [3:0]  wop;
    logic [9:0]  warg;
    o.status = ST_OK;
    o.rdata  = '0;
    case (command)
      CMD_LOAD: prog_words[address % PROGRAM_DEPTH_DEF] = {opcode, operand};
      CMD_READ: o.rdata = data_words[address % DATA_DEPTH_DEF];
      CMD_STEP: begin
        if (halted_q) begin
          o.status = ST_IGNORED;
        end else begin
          word = prog_words[pc_q];
          wop  = word[13:10];
          warg = word[9:0];
          pc_q = pc_q + 5'd1;
          case (wop)
            OP_NOP:   begin end
            OP_LOAD:  acc_q = data_words[warg];
            OP_ADD:   acc_q = acc_q + data_words[warg];
            OP_STORE: data_words[warg] = acc_q;
            OP_SUB:   acc_q = acc_q - data_words[warg];
            OP_IN:    acc_q = in_value;
            OP_OUT:   o.status = ST_OUTPUT;
            OP_END: begin
              o.status = ST_HALTED;
              halted_q = 1'b1;
            end
            OP_JUMP:  pc_q = 5'(warg % PROGRAM_DEPTH_DEF);
            OP_SKIPZ: if (acc_q == '0) pc_q = pc_q + 5'd1;
            default:  o.status = ST_BAD_OP;
          endcase
        end
      end
      default: begin end
    endcase
    o.pc  = pc_q;
    o.acc = acc_q;
  endtask

  always @(posedge clk) begin
    step_outcome_t want;
    if (rst) begin
      foreach (prog_words[i]) prog_words[i] = '0;
      foreach (data_words[i]) data_words[i] = '0;
      pc_q       = START_PC_RESET;
      acc_q      = '0;
      halted_q   = 1'b0;
      pending_outcomes.delete();
    end else begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with no request pending, expected none, actual status %0h",
                   $time, status);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(status));
          check_field("pc", 32'(want.pc), 32'(pc));
          check_field("accumulator", want.acc, accumulator);
          check_field("read_data", want.rdata, read_data);
        end
      end
      // Writing start_pc reloads the counter at once.
      if (cfg_we) begin
        pc_q = cfg_wdata;
      end
      if (start && !busy) begin
        predict_step(want);
        pending_outcomes.push_back(want);
      end
    end
    outstanding <= pending_outcomes.size();
    fail_count  <= mismatches;
  end

endmodule

[dv/accumulator_machine_step_core_tb.sv]
// Testbench top for the accumulator machine: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps

module accumulator_machine_step_core_tb;
  import ams_pkg::*;

  // Command 3 is not decoded; the block answers it with status ok.
  localparam logic [1:0]  CMD_SPARE = 2'd3;
  // Opcodes above the last defined one are reported as invalid.
  localparam logic [3:0]  OP_BAD_LO = 4'd10;
  localparam logic [3:0]  OP_BAD_HI = 4'd15;
  localparam logic [9:0]  ADDR_MAX  = 10'd1023;
  localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX  = 32'h7fff_ffff;
  localparam int          PHASE_REQUESTS = 120;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [9:0]  address;
  logic [3:0]  opcode;
  logic [9:0]  operand;
  logic [31:0] in_value;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        done;
  logic [2:0]  status;
  logic [4:0]  pc;
  logic [31:0] accumulator;
  logic [31:0] read_data;
  int          fail_count;
  int          outstanding;

  // Percentage of requests followed by an idle gap on the request side.
  int          idle_pct;
  logic [4:0]  halt_slot;

  accumulator_machine_step_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .address     (address),
    .opcode      (opcode),
    .operand     (operand),
    .in_value    (in_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .pc          (pc),
    .accumulator (accumulator),
    .read_data   (read_data)
  );

  ams_step_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .address     (address),
    .opcode      (opcode),
    .operand     (operand),
    .in_value    (in_value),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .done        (done),
    .status      (status),
    .pc          (pc),
    .accumulator (accumulator),
    .read_data   (read_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block stops answering. The slowest legal run, clearing
  // pass included, ends far below this.
  initial begin
    #2_000_000;
    $display("accumulator_machine_step_core_tb failed");
    $finish;
  end

  // Presents one request and holds it until the block takes it. Afterwards the
  // request line either stays high for the next request or drops for a gap,
  // which is mostly short and now and then long.
  task automatic issue(input logic [1:0] cmd, input logic [9:0] addr, input logic [3:0] op,
                       input logic [9:0] opnd, input logic [31:0] val);
    int gap;
    @(negedge clk);
    start    <= 1'b1;
    command  <= cmd;
    address  <= addr;
    opcode   <= op;
    operand  <= opnd;
    in_value <= val;
    do @(posedge clk); while (busy);
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic load_word(input logic [9:0] slot, input logic [3:0] op,
                           input logic [9:0] opnd);
    issue(CMD_LOAD, slot, op, opnd, 32'($urandom));
  endtask

  task automatic step_once(input logic [31:0] val);
    issue(CMD_STEP, 10'($urandom), 4'($urandom), 10'($urandom), val);
  endtask

  // The register may only change while the machine is idle, so the request
  // line is dropped and every pending result is allowed to come back first.
  // This also serves as the full drain of the request side between phases.
  task automatic set_start_pc(input logic [4:0] value);
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Addresses lean toward a handful of low slots so that stores, loads and
  // reads meet each other often; the rest spans the whole field.
  function automatic logic [9:0] pick_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 10'($urandom_range(0, 7));
    if (r < 90) return 10'($urandom);
    return (r < 95) ? ADDR_MAX : 10'd0;
  endfunction

  // Zero matters for the skip instruction; the extremes exercise wrapping.
  function automatic logic [31:0] pick_word_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 20) return WORD_MIN;
    if (r < 25) return WORD_MAX;
    if (r < 30) return '1;
    return $urandom;
  endfunction

  // One random request. Program words never hold the end opcode here, since a
  // halt cannot be undone without a second reset; halting is saved for the end.
  task automatic random_request();
    int         r;
    logic [3:0] op;
    if ($urandom_range(0, 99) < 20) begin
      op = 4'($urandom_range(OP_BAD_LO, OP_BAD_HI));
    end else begin
      op = 4'($urandom_range(OP_NOP, OP_SKIPZ));
    end
    if (op == OP_END) op = OP_STORE;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      load_word(pick_address(), op, pick_address());
    end else if (r < 80) begin
      step_once(pick_word_value());
    end else if (r < 95) begin
      issue(CMD_READ, pick_address(), 4'($urandom), 10'($urandom), 32'($urandom));
    end else begin
      issue(CMD_SPARE, 10'($urandom), 4'($urandom), 10'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    command   = CMD_LOAD;
    address   = '0;
    opcode    = OP_NOP;
    operand   = '0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_pct  = 30;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed program starting at slot 0. It walks through every opcode but nop
    // and end: the input takes the most negative word, store and add wrap it to
    // zero, the skip is then taken over an empty slot, subtract wraps back,
    // a second skip falls through, and the jump to the top address lands on
    // the last slot, whose increment wraps the counter to zero. The last
    // load also shows program slots wrapping modulo the depth.
    set_start_pc(5'd0);
    load_word(10'd0, OP_IN, 10'd0);
    load_word(10'd1, OP_STORE, ADDR_MAX);
    load_word(10'd2, OP_ADD, ADDR_MAX);
    load_word(10'd3, OP_SKIPZ, 10'd0);
    load_word(10'd5, OP_SUB, ADDR_MAX);
    load_word(10'd6, OP_LOAD, ADDR_MAX);
    load_word(10'd7, OP_SKIPZ, 10'd0);
    load_word(10'd8, OP_OUT, 10'd0);
    load_word(10'd9, OP_BAD_HI, 10'd0);
    load_word(10'd10, OP_JUMP, ADDR_MAX);
    load_word(ADDR_MAX, OP_SKIPZ, 10'd0);
    step_once(WORD_MIN);
    repeat (10) step_once(32'($urandom));
    issue(CMD_READ, ADDR_MAX, 4'($urandom), 10'($urandom), 32'($urandom));
    issue(CMD_SPARE, 10'($urandom), 4'($urandom), 10'($urandom), 32'($urandom));

    // Random phases, each under its own start_pc. The first runs without any
    // idle cycles so requests go back to back.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_start_pc(5'd31);
        2:       set_start_pc(5'd0);
        default: set_start_pc(5'($urandom_range(1, 30)));
      endcase
      idle_pct = (phase == 0) ? 0 : 40;
      repeat (PHASE_REQUESTS) random_request();
    end

    // Halt at the end: an end word at the start slot stops the machine, a
    // further step is ignored, while loads, reads and the spare command still
    // answer normally.
    halt_slot = 5'($urandom);
    set_start_pc(halt_slot);
    idle_pct = 30;
    load_word(10'(halt_slot), OP_END, 10'($urandom));
    step_once(32'($urandom));
    step_once(32'($urandom));
    load_word(pick_address(), OP_IN, pick_address());
    issue(CMD_READ, pick_address(), 4'($urandom), 10'($urandom), 32'($urandom));
    issue(CMD_SPARE, 10'($urandom), 4'($urandom), 10'($urandom), 32'($urandom));
    repeat (20) random_request();

    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    // Waiting on after the drain lets a stray extra result still be caught.
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("accumulator_machine_step_core_tb passed");
    end else begin
      $display("accumulator_machine_step_core_tb failed");
    end
    $finish;
  end

endmodule

[accumulator_machine_step_core.f]
+incdir+hdl
hdl/ams_pkg.sv
hdl/ams_alu.sv
hdl/ams_seq.sv
hdl/accumulator_machine_step_core.sv
dv/ams_step_checker.sv
dv/accumulator_machine_step_core_tb.sv
